FILE: hw/rtl/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types, header layout constants and width helpers for the BMP
// 24-bit stream decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

  // Largest image side the decoder accepts, default.
  localparam int DEFAULT_MAX_DIM = 4096;

  // Depth of the command queue between parser and output stage.
  localparam int QUEUE_DEPTH = 4;

  // Header layout: 14-byte file header + 40-byte info header.
  localparam int HDR_BYTES      = 54;
  localparam int HDR_LAST       = HDR_BYTES - 1;
  localparam int HDR_POS_W      = 6;
  localparam int INFO_HDR_BYTES = 40;
  localparam int BPP_TRUECOLOR  = 24;
  localparam int COMP_NONE      = 0;

  // Byte offsets of the fields that are kept.
  localparam int OFS_FILE_SIZE   = 2;
  localparam int OFS_DATA_OFFSET = 10;
  localparam int OFS_INFO_SIZE   = 14;
  localparam int OFS_WIDTH       = 18;
  localparam int OFS_HEIGHT      = 22;
  localparam int OFS_BIT_COUNT   = 28;
  localparam int OFS_COMPRESSION = 30;
  localparam int OFS_IMAGE_SIZE  = 34;

  // Result kinds.
  localparam logic EV_PIXEL  = 1'b0;
  localparam logic EV_REJECT = 1'b1;

  // Width of a row or column coordinate, 0 .. max_dim-1.
  function automatic int coord_bits(input int max_dim);
    int b;
    begin
      b = $clog2(max_dim);
      return (b < 1) ? 1 : b;
    end
  endfunction

  // Width that holds an image side itself, 1 .. max_dim (at least 2 bits,
  // so the row padding count can be taken from it).
  function automatic int side_bits(input int max_dim);
    int b;
    begin
      b = $clog2(max_dim + 1);
      return (b < 2) ? 2 : b;
    end
  endfunction

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic        event_res;
    logic [23:0] pixel_index;
    logic [23:0] pixel_color;
    logic        last_pixel;
  } out_item_t;

endpackage

FILE: hw/rtl/bmpd_queue.sv
// ----------------------------------------------------------------------------
// bmpd_queue
// Small register FIFO that decouples the byte parser from the output stage.
// ----------------------------------------------------------------------------
module bmpd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = slots[rd_ptr];

  // pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= CNT_W'(DEPTH)) && !(pop && !not_empty))
    else $error("queue count out of range or pop from empty queue");

endmodule

FILE: hw/rtl/bmpd_front.sv
// ----------------------------------------------------------------------------
// bmpd_front
// Byte parser: collects and checks the header, assembles pixels, tracks
// raster position and pushes one command per result into the queue.
// ----------------------------------------------------------------------------
module bmpd_front #(
  parameter int MAX_DIM = 4096,
  parameter int CMD_W   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  input  bmpd_pkg::in_item_t  byte_data,
  input  logic                q_full,
  output logic                cmd_push,
  output logic [CMD_W-1:0]    cmd_data
);

  import bmpd_pkg::*;

  localparam int IDX_W = coord_bits(MAX_DIM);
  localparam int DIM_W = side_bits(MAX_DIM);

  typedef struct packed {
    logic              kind;
    logic              last;
    logic [IDX_W-1:0]  top_row;
    logic [IDX_W-1:0]  column;
    logic [DIM_W-1:0]  width;
    logic [23:0]       color;
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_PIXELS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  phase_t               phase;
  phase_t               phase_next;
  logic [HDR_POS_W-1:0] header_position;

  logic [31:0] file_size;
  logic [31:0] data_offset;
  logic [31:0] info_size;
  logic [31:0] image_width;
  logic [31:0] image_height;
  logic [15:0] bit_count;
  logic [31:0] compression_kind;
  logic [31:0] image_size;

  logic [IDX_W-1:0] column;
  logic [IDX_W-1:0] top_row;
  logic [1:0]       byte_in_pixel;
  logic [15:0]      partial_color;
  logic [1:0]       pad_left;

  logic                 accept;
  logic [7:0]           b;
  phase_t               ph_cur;
  logic [HDR_POS_W-1:0] pos_cur;
  logic                 hdr_byte;
  logic                 hdr_end;
  logic                 hdr_ok;
  logic                 pix_byte;
  logic                 emit;
  logic [DIM_W-1:0]     width_r;
  logic                 col_last;
  logic                 is_last;
  cmd_t                 cmd;

  // restart on file_start, whatever the phase
  always_comb begin
    accept   = byte_valid && !q_full;
    b        = byte_data.data_byte;
    ph_cur   = byte_data.file_start ? PH_HEADER : phase;
    pos_cur  = byte_data.file_start ? '0 : header_position;
    hdr_byte = accept && (ph_cur == PH_HEADER);
    hdr_end  = hdr_byte && (pos_cur == HDR_POS_W'(HDR_LAST));
    pix_byte = accept && (ph_cur == PH_PIXELS);
    emit     = pix_byte && (pad_left == 2'd0) && (byte_in_pixel == 2'd2);
    width_r  = image_width[DIM_W-1:0];
    col_last = (DIM_W'(column) == width_r - 1'b1);
    is_last  = (top_row == '0) && col_last;
  end

  // header check, all fields are complete by the last header byte
  always_comb begin
    hdr_ok = (info_size == 32'(INFO_HDR_BYTES))
          && (data_offset == 32'(HDR_BYTES))
          && (compression_kind == 32'(COMP_NONE))
          && (bit_count == 16'(BPP_TRUECOLOR))
          && ((file_size - data_offset) == image_size)
          && (image_width != '0) && (image_width <= 32'(MAX_DIM))
          && (image_height != '0) && (image_height <= 32'(MAX_DIM));
  end

  // command toward the output stage
  always_comb begin
    cmd = '0;
    cmd_push = 1'b0;
    if (hdr_end && !hdr_ok) begin
      cmd_push = 1'b1;
      cmd.kind = EV_REJECT;
    end else if (emit) begin
      cmd_push    = 1'b1;
      cmd.kind    = EV_PIXEL;
      cmd.last    = is_last;
      cmd.top_row = top_row;
      cmd.column  = column;
      cmd.width   = width_r;
      cmd.color   = {b, partial_color};
    end
    cmd_data = cmd;
  end

  // phase sequencing
  always_comb begin
    phase_next = phase;
    if (accept) begin
      phase_next = ph_cur;
      if (hdr_end) begin
        phase_next = hdr_ok ? PH_PIXELS : PH_DONE;
      end else if (emit && is_last) begin
        phase_next = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      header_position <= '0;
    end else begin
      phase <= phase_next;
      if (hdr_byte) begin
        header_position <= pos_cur + 1'b1;
      end
    end
  end

  // header field capture, little-endian
  always_ff @(posedge clk) begin
    if (hdr_byte) begin
      if (pos_cur inside {[OFS_FILE_SIZE:OFS_FILE_SIZE+3]}) begin
        file_size[{2'(pos_cur - HDR_POS_W'(OFS_FILE_SIZE)), 3'b000} +: 8] <= b;
      end
      if (pos_cur inside {[OFS_DATA_OFFSET:OFS_DATA_OFFSET+3]}) begin
        data_offset[{2'(pos_cur - HDR_POS_W'(OFS_DATA_OFFSET)), 3'b000} +: 8] <= b;
      end
      if (pos_cur inside {[OFS_INFO_SIZE:OFS_INFO_SIZE+3]}) begin
        info_size[{2'(pos_cur - HDR_POS_W'(OFS_INFO_SIZE)), 3'b000} +: 8] <= b;
      end
      if (pos_cur inside {[OFS_WIDTH:OFS_WIDTH+3]}) begin
        image_width[{2'(pos_cur - HDR_POS_W'(OFS_WIDTH)), 3'b000} +: 8] <= b;
      end
      if (pos_cur inside {[OFS_HEIGHT:OFS_HEIGHT+3]}) begin
        image_height[{2'(pos_cur - HDR_POS_W'(OFS_HEIGHT)), 3'b000} +: 8] <= b;
      end
      if (pos_cur inside {[OFS_BIT_COUNT:OFS_BIT_COUNT+1]}) begin
        bit_count[{1'(pos_cur - HDR_POS_W'(OFS_BIT_COUNT)), 3'b000} +: 8] <= b;
      end
      if (pos_cur inside {[OFS_COMPRESSION:OFS_COMPRESSION+3]}) begin
        compression_kind[{2'(pos_cur - HDR_POS_W'(OFS_COMPRESSION)), 3'b000} +: 8] <= b;
      end
      if (pos_cur inside {[OFS_IMAGE_SIZE:OFS_IMAGE_SIZE+3]}) begin
        image_size[{2'(pos_cur - HDR_POS_W'(OFS_IMAGE_SIZE)), 3'b000} +: 8] <= b;
      end
    end
  end

  // pixel assembly and raster position; rows arrive bottom-up
  always_ff @(posedge clk) begin
    if (hdr_end && hdr_ok) begin
      column        <= '0;
      top_row       <= image_height[IDX_W-1:0] - 1'b1;
      byte_in_pixel <= 2'd0;
      pad_left      <= 2'd0;
    end else if (pix_byte) begin
      if (pad_left != 2'd0) begin
        pad_left <= pad_left - 1'b1;
      end else begin
        case (byte_in_pixel)
          2'd0: begin
            partial_color[7:0] <= b;
            byte_in_pixel      <= 2'd1;
          end
          2'd1: begin
            partial_color[15:8] <= b;
            byte_in_pixel       <= 2'd2;
          end
          2'd2: begin
            byte_in_pixel <= 2'd0;
            if (!is_last) begin
              if (col_last) begin
                column   <= '0;
                top_row  <= top_row - 1'b1;
                pad_left <= width_r[1:0];
              end else begin
                column <= column + 1'b1;
              end
            end
          end
          default: begin
            byte_in_pixel <= 2'd0;
          end
        endcase
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_pixels_after_header: assert property (@(posedge clk) disable iff (rst)
    $rose(phase == PH_PIXELS) |-> ($past(header_position) == HDR_POS_W'(HDR_LAST)))
    else $error("pixel phase entered before the header was complete");

  a_width_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PIXELS) |-> ((image_width != '0) && (image_width <= 32'(MAX_DIM))))
    else $error("pixel phase with image width out of range");

endmodule

FILE: hw/rtl/bmpd_back.sv
// ----------------------------------------------------------------------------
// bmpd_back
// Output stage: turns a queued command into a result, computing the
// top-down raster index, and holds it in the output register.
// ----------------------------------------------------------------------------
module bmpd_back #(
  parameter int MAX_DIM = 4096,
  parameter int CMD_W   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_not_empty,
  input  logic [CMD_W-1:0]    q_data,
  output logic                q_pop,
  output logic                result_valid,
  input  logic                result_stall,
  output bmpd_pkg::out_item_t result_data
);

  import bmpd_pkg::*;

  localparam int IDX_W  = coord_bits(MAX_DIM);
  localparam int DIM_W  = side_bits(MAX_DIM);
  localparam int PROD_W = IDX_W + DIM_W;

  typedef struct packed {
    logic              kind;
    logic              last;
    logic [IDX_W-1:0]  top_row;
    logic [IDX_W-1:0]  column;
    logic [DIM_W-1:0]  width;
    logic [23:0]       color;
  } cmd_t;

  cmd_t              cmd;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] index_full;

  // index = top_row * width + column
  always_comb begin
    cmd        = cmd_t'(q_data);
    prod       = PROD_W'(cmd.top_row) * PROD_W'(cmd.width);
    index_full = prod + PROD_W'(cmd.column);
    q_pop      = q_not_empty && (!result_valid || !result_stall);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (q_pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result_data.event_res   <= cmd.kind;
      result_data.pixel_index <= 24'(index_full);
      result_data.pixel_color <= cmd.color;
      result_data.last_pixel  <= cmd.last;
    end
  end

endmodule

FILE: hw/rtl/bmp_24bit_stream_decoder.sv
// ----------------------------------------------------------------------------
// bmp_24bit_stream_decoder
// Streaming decoder for uncompressed 24-bit BMP files, one byte per request.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle; file_start marks byte 0 of a file and
// restarts the parser at any time. The 54-byte header is captured and checked
// on its last byte (info size 40, data offset 54, no compression, 24 bits per
// pixel, file size minus offset equal to image size, width and height in
// 1..MAX_DIM); a failing header gives one reject result and the rest of the
// file is dropped. Each later blue/green/red triple gives one pixel result
// with its top-down raster index, row padding is skipped and the final pixel
// is flagged. Between the byte that completes a result and the result itself,
// the parser pushes into a four-entry command queue and the output stage
// forms the index with one multiply-add into the output register. Bytes are
// taken every cycle as long as the queue has room, so stalls on the result
// side reach the byte side only once four results wait in the queue behind
// the one held in the output register.
module bmp_24bit_stream_decoder #(
  parameter int MAX_DIM = bmpd_pkg::DEFAULT_MAX_DIM
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  bmpd_pkg::in_item_t  byte_data,
  output logic                result_valid,
  input  logic                result_stall,
  output bmpd_pkg::out_item_t result_data
);

  import bmpd_pkg::*;

  localparam int IDX_W = coord_bits(MAX_DIM);
  localparam int DIM_W = side_bits(MAX_DIM);
  localparam int CMD_W = 2 + 2 * IDX_W + DIM_W + 24;

  logic             q_full;
  logic             q_not_empty;
  logic             q_pop;
  logic             cmd_push;
  logic [CMD_W-1:0] cmd_data;
  logic [CMD_W-1:0] q_data;

  assign byte_stall = q_full;

  // parser
  bmpd_front #(
    .MAX_DIM (MAX_DIM),
    .CMD_W   (CMD_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .q_full     (q_full),
    .cmd_push   (cmd_push),
    .cmd_data   (cmd_data)
  );

  // command queue
  bmpd_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .wr_data   (cmd_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_data   (q_data)
  );

  // output stage
  bmpd_back #(
    .MAX_DIM (MAX_DIM),
    .CMD_W   (CMD_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule
